// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier
package bpc_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgW-1:0] DoubleRst   = 16'd300;
  localparam logic [CfgW-1:0] LongRst     = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DOUBLE   = 2'd1,
    REG_LONG     = 2'd2
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } press_kind_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] double_click_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

endpackage

// ===== rtl/bpc_if.sv =====
// Valid/ready channel interfaces for sample and result items
interface bpc_in_if
  import bpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             pin_level;
  logic [TimeW-1:0] time_ms;

  modport source (output valid, output pin_level, output time_ms, input ready);
  modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface

interface bpc_out_if
  import bpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] press_kind;

  modport source (output valid, output press_kind, input ready);
  modport sink   (input valid, input press_kind, output ready);
endinterface

// ===== rtl/bpc_core.sv =====
// Debounce and gesture state with per-sample press classification
module bpc_core
  import bpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             pin_level_i,
  input  logic [TimeW-1:0] time_ms_i,
  input  cfg_t             cfg_i,
  output press_kind_e      kind_o
);

  logic             prev_raw_q, prev_raw_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_t_q, change_t_d;
  logic [TimeW-1:0] press_t_q, press_t_d;
  logic [TimeW-1:0] release_t_q, release_t_d;
  logic             awaiting_q, awaiting_d;
  logic             long_rep_q, long_rep_d;
  logic             held_q, held_d;

  logic [TimeW-1:0] deb_ext, dbl_ext, long_ext;
  press_kind_e      kind;

  assign deb_ext  = {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms};
  assign dbl_ext  = {{(TimeW-CfgW){1'b0}}, cfg_i.double_click_ms};
  assign long_ext = {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms};

  always_comb begin
    kind        = KIND_NONE;
    prev_raw_d  = prev_raw_q;
    stable_d    = stable_q;
    change_t_d  = change_t_q;
    press_t_d   = press_t_q;
    release_t_d = release_t_q;
    awaiting_d  = awaiting_q;
    long_rep_d  = long_rep_q;
    held_d      = held_q;

    if (pin_level_i != prev_raw_q) begin
      change_t_d = time_ms_i;
    end

    if ((time_ms_i - change_t_d) > deb_ext && pin_level_i != stable_q) begin
      stable_d = pin_level_i;
      if (!pin_level_i) begin
        press_t_d  = time_ms_i;
        long_rep_d = 1'b0;
        held_d     = 1'b1;
      end else begin
        held_d = 1'b0;
        if (!long_rep_q) begin
          if (awaiting_q && (time_ms_i - release_t_q) <= dbl_ext) begin
            kind       = KIND_DOUBLE;
            awaiting_d = 1'b0;
          end else begin
            awaiting_d  = 1'b1;
            release_t_d = time_ms_i;
          end
        end
        long_rep_d = 1'b0;
      end
    end

    prev_raw_d = pin_level_i;

    if (held_d && !long_rep_d && (time_ms_i - press_t_d) >= long_ext) begin
      kind       = KIND_LONG;
      long_rep_d = 1'b1;
      awaiting_d = 1'b0;
    end

    if (!held_d && awaiting_d && (time_ms_i - release_t_d) > dbl_ext) begin
      kind       = KIND_SINGLE;
      awaiting_d = 1'b0;
    end
  end

  assign kind_o = kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= 1'b1;
      stable_q    <= 1'b1;
      change_t_q  <= '0;
      press_t_q   <= '0;
      release_t_q <= '0;
      awaiting_q  <= 1'b0;
      long_rep_q  <= 1'b0;
      held_q      <= 1'b0;
    end else if (accept_i) begin
      prev_raw_q  <= prev_raw_d;
      stable_q    <= stable_d;
      change_t_q  <= change_t_d;
      press_t_q   <= press_t_d;
      release_t_q <= release_t_d;
      awaiting_q  <= awaiting_d;
      long_rep_q  <= long_rep_d;
      held_q      <= held_d;
    end
  end

endmodule

// ===== rtl/button_press_classifier_top.sv =====
// Top level of the button press classifier
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    pin_level, time_ms
//   out_o    out  valid/ready    press_kind
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One sample per cycle unless stalled; its result item appears in the output
// register in the cycle after acceptance. The state update and classification
// sit between the gesture state registers and the output register. A stalled
// result holds in the output register; a sample is taken while the result is
// being taken in the same cycle. Reset restores all registers.
module button_press_classifier_top
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  bpc_in_if.sink             in_i,
  bpc_out_if.source          out_o
);

  cfg_t             cfg_q;
  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic             accept;
  press_kind_e      kind;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  bpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pin_level_i (in_i.pin_level),
    .time_ms_i   (in_i.time_ms),
    .cfg_i       (cfg_q),
    .kind_o      (kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.double_click_ms <= DoubleRst;
      cfg_q.long_press_ms   <= LongRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data_i;
        REG_DOUBLE:   cfg_q.double_click_ms <= cfg_data_i;
        REG_LONG:     cfg_q.long_press_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    if (accept) begin
      out_valid_d = 1'b1;
      kind_d      = kind;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
    end else begin
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.press_kind = kind_q;

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level checks for the button press classifier and their binding
`include "assert_macros.svh"

module bpc_checker
  import bpc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [KindW-1:0] press_kind_i
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  `BPC_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(press_kind_i))
  `BPC_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_valid_i)
  `BPC_ASSERT_NOW(a_no_overrun, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)
  `BPC_ASSERT_NEXT(a_no_invented, clk_i, rst_ni, !in_acc && (out_acc || !out_valid_i), !out_valid_i)

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .press_kind_i (out_o.press_kind)
);
